### rtl/lgs_pkg.sv
// shared constants, register codes and the b3/s23 cell rule for the life stencil
// no dependencies; used by life_generation_stencil
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  // configuration register width and codes
  localparam int unsigned CfgW = 10;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_index_e;

  localparam logic [CfgW-1:0] CfgDimReset = 10'd512;

  // smallest grid dimension, and the neighbor counts of the rule
  localparam int unsigned MinDim     = 3;
  localparam logic [3:0]  BirthCount = 4'd3;
  localparam logic [3:0]  StayCount  = 4'd2;

  // stream byte width
  localparam int unsigned TDataW = 8;

  // window bit = column*3 + row, column 0 oldest, row 0 top; bit 4 is the center
  function automatic logic life_rule(input logic [8:0] win);
    logic [3:0] count;
    count = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        count = count + {3'd0, win[i]};
      end
    end
    return (count == BirthCount) || (win[4] && (count == StayCount));
  endfunction

endpackage

`default_nettype wire

### rtl/life_generation_stencil.sv
// one generation of the b3/s23 automaton over a raster cell stream, two line memories
// depends on lgs_pkg
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata[0] curr_live
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata[0] next_alive, tlast last_of_frame
//  cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one cell per cycle sustained while the output is not stalled; at its input transfer
// a cell and its line memory reads are registered in stage 1, then the window update
// and rule put its result in the output register. after reset both line memories are
// cleared one entry a cycle, and no cell is taken during that pass; config writes are
// taken at any time. a stalled output holds the result stage; the input keeps flowing
// while a cell that gives no result passes or the output register is free or drained.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_stencil #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // config write channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire                          cfg_index_i,
  input  wire  [lgs_pkg::CfgW-1:0]     cfg_data_i,
  // cell stream in
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [lgs_pkg::TDataW-1:0]   s_axis_tdata,   // [0] curr_live
  // next generation out
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [lgs_pkg::TDataW-1:0]   m_axis_tdata,   // [0] next_alive
  output logic                         m_axis_tlast    // last_of_frame
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CmpW = (CW > lgs_pkg::CfgW) ? CW : lgs_pkg::CfgW;
  localparam int unsigned CmpH = (RW > lgs_pkg::CfgW) ? RW : lgs_pkg::CfgW;

  // config registers
  logic [lgs_pkg::CfgW-1:0] grid_width_q, grid_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= lgs_pkg::CfgDimReset;
      grid_height_q <= lgs_pkg::CfgDimReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lgs_pkg::cfg_index_e'(cfg_index_i))
        lgs_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        lgs_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective dimensions clamped to [3, max]
  logic [CW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic [CmpW-1:0] gw_ext;
  logic [CmpH-1:0] gh_ext;

  always_comb begin
    gw_ext = CmpW'(grid_width_q);
    gh_ext = CmpH'(grid_height_q);
    if (gw_ext < CmpW'(lgs_pkg::MinDim))  w_eff = CW'(lgs_pkg::MinDim);
    else if (gw_ext > CmpW'(MAX_WIDTH))   w_eff = CW'(MAX_WIDTH);
    else                                  w_eff = CW'(gw_ext);
    if (gh_ext < CmpH'(lgs_pkg::MinDim))  h_eff = RW'(lgs_pkg::MinDim);
    else if (gh_ext > CmpH'(MAX_HEIGHT))  h_eff = RW'(MAX_HEIGHT);
    else                                  h_eff = RW'(gh_ext);
  end

  // clearing pass after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // stage 0: position tracking and line memory read
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] c0, c_inc;
  logic [RW-1:0] r0;
  logic          s0_final, s0_cur, s0_emit;
  logic          in_fire;

  always_comb begin
    if (col_q >= w_eff) begin
      c0 = '0;
      r0 = row_q + RW'(1);
    end else begin
      c0 = col_q;
      r0 = row_q;
    end
    s0_final = (r0 >= h_eff + RW'(1));
    s0_cur   = (r0 < h_eff) && s_axis_tdata[0];
    s0_emit  = s0_final || ((r0 >= RW'(1)) && ((c0 >= CW'(1)) || (r0 >= RW'(2))));
    c_inc    = c0 + CW'(1);
    priority if (s0_final) begin
      col_d = '0;
      row_d = '0;
    end else if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = r0 + RW'(1);
    end else begin
      col_d = c_inc;
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers
  logic          s1_valid_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_cur_q, s1_up_en_q, s1_mid_en_q, s1_restart_q, s1_final_q, s1_emit_q;
  logic          rd_upper_q, rd_middle_q;
  logic          s1_go, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q    <= c0[AW-1:0];
      s1_cur_q     <= s0_cur;
      s1_up_en_q   <= (r0 >= RW'(2));
      s1_mid_en_q  <= (r0 >= RW'(1));
      s1_restart_q <= (c0 == '0) || s0_final;
      s1_final_q   <= s0_final;
      s1_emit_q    <= s0_emit;
    end
  end

  // line memories: read on input transfer, write back from stage 1
  logic row_store_upper  [MAX_WIDTH];
  logic row_store_middle [MAX_WIDTH];
  logic up, mid;

  assign up  = s1_up_en_q && rd_upper_q;
  assign mid = s1_mid_en_q && rd_middle_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      row_store_upper[clr_addr_q] <= 1'b0;
    end else if (s1_go) begin
      row_store_upper[s1_addr_q] <= mid;
    end
    if (in_fire) begin
      rd_upper_q <= row_store_upper[c0[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      row_store_middle[clr_addr_q] <= 1'b0;
    end else if (s1_go) begin
      row_store_middle[s1_addr_q] <= s1_cur_q;
    end
    if (in_fire) begin
      rd_middle_q <= row_store_middle[c0[AW-1:0]];
    end
  end

  // 3x3 window and rule
  logic [8:0] win_q, win_d, eval;
  logic [2:0] col_bits;

  always_comb begin
    col_bits = {s1_cur_q, mid, up};
    if (s1_restart_q) begin
      eval  = {3'b000, win_q[8:3]};
      win_d = {col_bits, 6'b0};
    end else begin
      eval  = {col_bits, win_q[8:3]};
      win_d = eval;
    end
    if (s1_final_q) begin
      win_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_go) begin
      win_q <= win_d;
    end
  end

  // output register
  logic out_valid_q, out_alive_q, out_last_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!s1_emit_q || out_free);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_go);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      out_alive_q <= lgs_pkg::life_rule(eval);
      out_last_q  <= s1_final_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lgs_pkg::TDataW-1){1'b0}}, out_alive_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  // the first cell of a frame may reuse the entry just written, but its read is masked
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s1_go && (r0 >= RW'(1))) |-> (c0[AW-1:0] != s1_addr_q))
    else $error("line memory read and write hit the same entry");

  a_out_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(s1_go && s1_emit_q))
    else $error("stalled result overwritten");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s0_final) |=> ((col_q == '0) && (row_q == '0)))
    else $error("positions not cleared after frame end");

endmodule

`default_nettype wire

### test/tb.sv
// self-checking bench for life_generation_stencil: cell frames with next-state prediction
// depends on lgs_pkg and rtl/life_generation_stencil.sv
// covers directed patterns, extreme and clamped grid sizes, mid-frame resizing, random idling
`timescale 1ns / 1ps

module tb;

  localparam int unsigned GridMax = 512;
  localparam int unsigned DimW    = lgs_pkg::CfgW;
  localparam int unsigned DataW   = lgs_pkg::TDataW;

  typedef struct packed {
    logic next_alive;
    logic last_of_frame;
  } gen_result_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  lgs_pkg::cfg_index_e cfg_index_i   = lgs_pkg::CFG_GRID_WIDTH;
  logic [DimW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataW-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  life_generation_stencil #(
    .MAX_WIDTH (GridMax),
    .MAX_HEIGHT(GridMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predictor state: the two rows above the incoming one, the 3x3 window, the raster position
  logic            line_two_up [GridMax] = '{default: 1'b0};
  logic            line_one_up [GridMax] = '{default: 1'b0};
  logic [8:0]      window_bits    = '0;
  logic [9:0]      col_pos        = '0;
  logic [9:0]      row_pos        = '0;
  logic [DimW-1:0] grid_w_setting = lgs_pkg::CfgDimReset;
  logic [DimW-1:0] grid_h_setting = lgs_pkg::CfgDimReset;

  logic        pending_cells [$];
  gen_result_t next_gen_due  [$];

  int unsigned mismatch_count = 0;
  int unsigned cells_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_done    = 0;
  bit          steady_flow    = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int unsigned effective_dim(input logic [DimW-1:0] v);
    if (v < DimW'(lgs_pkg::MinDim)) return lgs_pkg::MinDim;
    if (v > DimW'(GridMax)) return GridMax;
    return 32'(v);
  endfunction

  function automatic logic alive_next(input logic [8:0] win);
    int unsigned n;
    n = $countones(win & 9'h1EF);  // neighbors only, center excluded
    return (n == 3) || (win[4] && n == 2);
  endfunction

  // one accepted cell: update the line stores and window, queue the result it releases
  function automatic void advance_cell(input logic cell_in);
    int unsigned w, h, c, r;
    logic        is_last, emit, cur, up, mid;
    logic [2:0]  column;
    logic [8:0]  eval;
    gen_result_t res;
    w = effective_dim(grid_w_setting);
    h = effective_dim(grid_h_setting);
    c = 32'(col_pos);
    r = 32'(row_pos);
    if (c >= w) begin
      c = 0;
      r++;
    end
    is_last = (r >= h + 1);
    cur = (r < h) ? cell_in : 1'b0;
    up  = (r >= 2) ? line_two_up[c] : 1'b0;
    mid = (r >= 1) ? line_one_up[c] : 1'b0;
    line_two_up[c] = mid;
    line_one_up[c] = cur;
    column = {cur, mid, up};
    if (c == 0 || is_last) begin
      // row start or frame end: the window shifts in a dead column
      eval = {3'b000, window_bits[8:3]};
      window_bits = {column, 6'b0};
    end else begin
      eval = {column, window_bits[8:3]};
      window_bits = eval;
    end
    emit = is_last || (r >= 1 && (c >= 1 || r >= 2));
    if (is_last) begin
      col_pos = '0;
      row_pos = '0;
      window_bits = '0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c[9:0];
      row_pos = r[9:0];
    end
    if (emit) begin
      res.next_alive    = alive_next(eval);
      res.last_of_frame = is_last;
      next_gen_due.push_back(res);
    end
  endfunction

  function automatic int unsigned frame_cells();
    int unsigned w, h;
    w = effective_dim(grid_w_setting);
    h = effective_dim(grid_h_setting);
    return w * h + w + 1;
  endfunction

  // only valid while the block is idle, since it reads the predictor position
  function automatic int unsigned cells_to_frame_end();
    int unsigned w, h, c, r;
    w = effective_dim(grid_w_setting);
    h = effective_dim(grid_h_setting);
    c = 32'(col_pos);
    r = 32'(row_pos);
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h + 1) return 1;
    return (h + 1 - r) * w - c + 1;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return DimW'($urandom_range(0, 2));
    if (roll < 85) return DimW'($urandom_range(3, 10));
    return DimW'($urandom_range(11, 24));
  endfunction

  function automatic int unsigned pick_density();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return 100;
    return $urandom_range(15, 60);
  endfunction

  task automatic queue_cells(input int unsigned count, input int unsigned density);
    repeat (count) pending_cells.push_back($urandom_range(0, 99) < density);
  endtask

  task automatic write_reg(input lgs_pkg::cfg_index_e idx, input logic [DimW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == lgs_pkg::CFG_GRID_WIDTH) grid_w_setting = value;
    else grid_h_setting = value;
  endtask

  // hold the sender until every result is back, then let cells without results clear
  task automatic settle();
    do @(posedge clk_i);
    while (pending_cells.size() != 0 || s_axis_tvalid || next_gen_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // cell sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_cell(s_axis_tdata[0]);
        cells_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pending_cells.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(DataW-1){1'b0}}, pending_cells.pop_front()};
          send_gap      <= idle_length();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    gen_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (next_gen_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = next_gen_due.pop_front();
          if (m_axis_tdata[0] !== want.next_alive)
            report_mismatch($sformatf("result %0d: next_alive %b, expected %b",
                                      results_seen, m_axis_tdata[0], want.next_alive));
          if (m_axis_tlast !== want.last_of_frame)
            report_mismatch($sformatf("result %0d: tlast %b, expected %b",
                                      results_seen, m_axis_tlast, want.last_of_frame));
          if (want.last_of_frame) frames_done++;
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left    <= idle_length();
      end
    end
  end

  initial begin
    int unsigned random_cells;
    int unsigned density;
    int unsigned n;
    random_cells = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 3x3 grid via a width below the minimum: vertical blinker, then a full grid
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 10'd0);
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 10'd3);
    repeat (3) begin
      pending_cells.push_back(1'b0);
      pending_cells.push_back(1'b1);
      pending_cells.push_back(1'b0);
    end
    repeat (4) pending_cells.push_back(1'b1);  // filler values must be ignored
    repeat (9) pending_cells.push_back(1'b1);
    repeat (4) pending_cells.push_back(1'b0);
    settle();

    // widest grid (clamped from all ones), then shrink the width mid-frame
    steady_flow = 1'b1;
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 10'h3FF);
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 10'd0);
    queue_cells(2 * GridMax + 10, 40);
    settle();
    steady_flow = 1'b0;
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 10'd5);
    queue_cells(cells_to_frame_end(), 50);
    settle();

    // tallest grid, cut short by a smaller height so the next cell closes the frame
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 10'd1);
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 10'd512);
    queue_cells(60, 50);
    settle();
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 10'd2);
    queue_cells(cells_to_frame_end(), 50);
    settle();

    // random frames, mostly small, some back to back, some resized mid-frame
    while (random_cells < 250) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) write_reg(lgs_pkg::CFG_GRID_WIDTH, pick_dim());
      if ($urandom_range(0, 1)) write_reg(lgs_pkg::CFG_GRID_HEIGHT, pick_dim());
      repeat ($urandom_range(1, 3)) begin
        queue_cells(frame_cells(), pick_density());
        random_cells += frame_cells();
      end
      if ($urandom_range(0, 4) == 0) begin
        density = pick_density();
        n = $urandom_range(1, frame_cells() - 1);
        queue_cells(n, density);
        random_cells += n;
        settle();
        if ($urandom_range(0, 1)) write_reg(lgs_pkg::CFG_GRID_WIDTH, pick_dim());
        else write_reg(lgs_pkg::CFG_GRID_HEIGHT, pick_dim());
        n = cells_to_frame_end();
        queue_cells(n, density);
        random_cells += n;
      end
      settle();
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("run summary: %0d cells in, %0d next-state results checked, %0d frames closed",
             cells_sent, results_seen, frames_done);
    $display("grids from 3x3 to 512 wide and 512 tall, clamped settings, mid-frame resizing");
    if (mismatch_count == 0 && next_gen_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("watchdog expired with %0d results outstanding", next_gen_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
